// File: rtl/median_window_outlier_filter_core_defines.svh
// Assertion macros shared by the checker of the median window outlier filter.
// No dependencies; included by rtl/mwof_checker.sv.
`ifndef MEDIAN_WINDOW_OUTLIER_FILTER_CORE_DEFINES_SVH
`define MEDIAN_WINDOW_OUTLIER_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWOF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MWOF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mwof_pkg.sv
// Shared types and constants of the median window outlier filter.
// No dependencies; used by mwof_ctrl, mwof_datapath and the top level.
package mwof_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_UP_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_OFFSET = 2'd2;

    // Reset values of the configuration registers
    localparam int UP_LIMIT_RST    = 10;
    localparam int DOWN_LIMIT_RST  = 30;
    localparam int DOWN_OFFSET_RST = 10;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic shift;     // accepted beat: push point into window
        logic setup;     // start of a slot: latch point, clear or load reference
        logic full;      // slot has a full window: reference is the median
        logic scan;      // add window y at rd_idx into the sum
        logic div_step;  // one bit of the mean division
        logic load;      // move resolved point into the output register
        logic last;      // output beat ends the run
    } mwof_cmd_t;

endpackage

// File: rtl/median_window_outlier_filter_core.sv
// Beat with no result (first WINDOW_SIZE/2 of a run): accept only. Interior point (full window,
// median by combinational rank select): accept, setup, emit. Edge point (mean): accept, setup,
// n sum steps, one divider step per sum bit (COORD_BITS+clog2(WINDOW_SIZE) bits), emit;
// n = clipped window size. Emit waits for a free output register. A run end flushes up to
// WINDOW_SIZE/2+1 points in a row, each slot without an accept; output lags by WINDOW_SIZE/2
// points. Reset (rst_n low, async) clears counters and output valid, and resets the limits.
module median_window_outlier_filter_core #(
    parameter int WINDOW_SIZE = 7,
    parameter int COORD_BITS  = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // fields from bit 0: point_x, point_y, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // fields from bit 0: out_x, out_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [mwof_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [COORD_BITS-1:0]                 cfg_data
);

    localparam int TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    mwof_pkg::mwof_cmd_t              cmd;
    logic [$clog2(WINDOW_SIZE)-1:0]   rd_idx;
    logic [$clog2(WINDOW_SIZE+1)-1:0] divisor;
    logic                             out_free;
    logic [COORD_BITS-1:0]            out_x, out_y;

    mwof_ctrl #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .COORD_BITS  (COORD_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .out_free (out_free),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .divisor  (divisor)
    );

    mwof_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_idx    (rd_idx),
        .divisor   (divisor),
        .point_x   (s_tdata[COORD_BITS-1:0]),
        .point_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_last  (m_tlast)
    );

    // Output beat packing, zero padded
    assign m_tdata = TDATA_W'({out_y, out_x});

endmodule

// File: rtl/mwof_datapath.sv
// Datapath: point window, config registers, median rank select, mean divider,
// outlier resolve and output register. Depends on mwof_pkg.
module mwof_datapath #(
    parameter int WINDOW_SIZE = 7,
    parameter int COORD_BITS  = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mwof_pkg::mwof_cmd_t           cmd,
    input  logic [$clog2(WINDOW_SIZE)-1:0]   rd_idx,
    input  logic [$clog2(WINDOW_SIZE+1)-1:0] divisor,
    input  logic [COORD_BITS-1:0]         point_x,
    input  logic [COORD_BITS-1:0]         point_y,
    input  logic                          cfg_we,
    input  logic [mwof_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [COORD_BITS-1:0]         cfg_data,
    output logic                          out_free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COORD_BITS-1:0]         out_x,
    output logic [COORD_BITS-1:0]         out_y,
    output logic                          out_last
);

    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int HALF  = WINDOW_SIZE / 2;
    localparam int SUM_W = COORD_BITS + $clog2(WINDOW_SIZE);
    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    logic [COORD_BITS-1:0] win_x_reg [WINDOW_SIZE];
    logic [COORD_BITS-1:0] win_y_reg [WINDOW_SIZE];
    logic [COORD_BITS-1:0] up_reg, down_reg, off_reg;
    logic [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic [SUM_W-1:0]      acc_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic                  valid_reg;
    logic [COORD_BITS-1:0] ox_reg, oy_reg;
    logic                  olast_reg;

    logic [CNT_W-1:0]      rank [WINDOW_SIZE];
    logic [COORD_BITS-1:0] median;
    logic [CNT_W:0]        trial, trial_sub;
    logic                  trial_ge;
    logic [COORD_BITS-1:0] ref_y;
    logic [COORD_BITS:0]   off_sum;
    logic                  up_hit, down_hit;
    logic [COORD_BITS-1:0] res_y;

    // Window shift line, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            for (int i = 0; i < WINDOW_SIZE - 1; i++)
            begin
                win_x_reg[i] <= win_x_reg[i+1];
                win_y_reg[i] <= win_y_reg[i+1];
            end
            win_x_reg[WINDOW_SIZE-1] <= point_x;
            win_y_reg[WINDOW_SIZE-1] <= point_y;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= COORD_BITS'(mwof_pkg::UP_LIMIT_RST);
            down_reg <= COORD_BITS'(mwof_pkg::DOWN_LIMIT_RST);
            off_reg  <= COORD_BITS'(mwof_pkg::DOWN_OFFSET_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                mwof_pkg::REG_UP_LIMIT:    up_reg   <= cfg_data;
                mwof_pkg::REG_DOWN_LIMIT:  down_reg <= cfg_data;
                mwof_pkg::REG_DOWN_OFFSET: off_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Median of a full window: rank every entry, ties broken by position
    always_comb
    begin
        median = '0;
        for (int j = 0; j < WINDOW_SIZE; j++)
        begin
            rank[j] = '0;
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                if (i != j && (win_y_reg[i] < win_y_reg[j] ||
                               (win_y_reg[i] == win_y_reg[j] && i < j)))
                begin
                    rank[j] = rank[j] + 1'b1;
                end
            end
            if (rank[j] == CNT_W'(HALF))
            begin
                median = win_y_reg[j];
            end
        end
    end

    // Restoring divider step: dividend and quotient share the sum register
    always_comb
    begin
        trial     = {rem_reg, acc_reg[SUM_W-1]};
        trial_ge  = (trial >= {1'b0, divisor});
        trial_sub = trial - {1'b0, divisor};
    end

    // Sum, median load and division
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            cur_x_reg <= win_x_reg[rd_idx];
            cur_y_reg <= win_y_reg[rd_idx];
            acc_reg   <= cmd.full ? SUM_W'(median) : '0;
            rem_reg   <= '0;
        end
        else if (cmd.scan)
        begin
            acc_reg <= acc_reg + SUM_W'(win_y_reg[rd_idx]);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            acc_reg <= {acc_reg[SUM_W-2:0], trial_ge};
        end
    end

    // Outlier resolve against the reference
    always_comb
    begin
        ref_y    = acc_reg[COORD_BITS-1:0];
        off_sum  = {1'b0, ref_y} + {1'b0, off_reg};
        up_hit   = (ref_y > cur_y_reg) && ((ref_y - cur_y_reg) > up_reg);
        down_hit = (cur_y_reg > ref_y) && ((cur_y_reg - ref_y) > down_reg);
        if (up_hit)
            res_y = ref_y;
        else if (down_hit)
            res_y = off_sum[COORD_BITS] ? COORD_MAX : off_sum[COORD_BITS-1:0];
        else
            res_y = cur_y_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ox_reg    <= cur_x_reg;
            oy_reg    <= res_y;
            olast_reg <= cmd.last;
        end
    end

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_last  = olast_reg;

endmodule

// File: rtl/mwof_ctrl.sv
// Controller: run counters, emit scheduling and the per-slot sequence.
// Depends on mwof_pkg; drives mwof_datapath through mwof_cmd_t.
module mwof_ctrl #(
    parameter int WINDOW_SIZE = 7,
    parameter int COORD_BITS  = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_last,
    output logic                             in_ready,
    input  logic                             out_free,
    output mwof_pkg::mwof_cmd_t              cmd,
    output logic [$clog2(WINDOW_SIZE)-1:0]   rd_idx,
    output logic [$clog2(WINDOW_SIZE+1)-1:0] divisor
);

    localparam int IDX_W  = $clog2(WINDOW_SIZE);
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int HALF   = WINDOW_SIZE / 2;
    localparam int SUM_W  = COORD_BITS + $clog2(WINDOW_SIZE);
    localparam int DCNT_W = $clog2(SUM_W);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(WINDOW_SIZE - 1);
    localparam logic [IDX_W-1:0] MID_POS  = IDX_W'(WINDOW_SIZE - 1 - HALF);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    seen_reg, seen_next;
    logic [CNT_W-1:0]    pend_reg, pend_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic                flush_reg, flush_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;

    logic [CNT_W-1:0]    seen_inc, pend_inc;
    logic [CNT_W:0]      pos_w, first_w, lo_w, hi_w, cnt_w;
    logic                full;

    // Clipped window bounds of the current slot
    always_comb
    begin
        pos_w   = (CNT_W+1)'(pos_reg);
        first_w = (CNT_W+1)'(WINDOW_SIZE) - {1'b0, seen_reg};
        if (pos_w >= first_w + (CNT_W+1)'(HALF))
            lo_w = pos_w - (CNT_W+1)'(HALF);
        else
            lo_w = first_w;
        if (pos_w + (CNT_W+1)'(HALF) > (CNT_W+1)'(WINDOW_SIZE - 1))
            hi_w = (CNT_W+1)'(WINDOW_SIZE - 1);
        else
            hi_w = pos_w + (CNT_W+1)'(HALF);
        cnt_w = hi_w - lo_w + 1'b1;
        full  = (cnt_w == (CNT_W+1)'(WINDOW_SIZE));
    end

    assign divisor = cnt_w[CNT_W-1:0];

    // Saturating run counters
    always_comb
    begin
        seen_inc = (seen_reg == CNT_W'(WINDOW_SIZE)) ? seen_reg : seen_reg + 1'b1;
        pend_inc = (pend_reg == CNT_W'(HALF + 1)) ? pend_reg : pend_reg + 1'b1;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        pend_next  = pend_reg;
        pos_next   = pos_reg;
        flush_next = flush_reg;
        idx_next   = idx_reg;
        dcnt_next  = dcnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        rd_idx     = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.shift = 1'b1;
                    seen_next = seen_inc;
                    if (in_last)
                    begin
                        // flush every pending point, oldest first
                        pos_next   = IDX_W'(CNT_W'(WINDOW_SIZE) - pend_inc);
                        flush_next = 1'b1;
                        pend_next  = '0;
                        state_next = S_SETUP;
                    end
                    else if (pend_inc > CNT_W'(HALF))
                    begin
                        pos_next   = MID_POS;
                        flush_next = 1'b0;
                        pend_next  = CNT_W'(HALF);
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        pend_next = pend_inc;
                    end
                end
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                cmd.full  = full;
                idx_next  = lo_w[IDX_W-1:0];
                state_next = full ? S_EMIT : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                rd_idx   = idx_reg;
                if (idx_reg == hi_w[IDX_W-1:0])
                begin
                    dcnt_next  = DCNT_W'(SUM_W - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (dcnt_reg == '0)
                    state_next = S_EMIT;
                else
                    dcnt_next = dcnt_reg - 1'b1;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.last = flush_reg && (pos_reg == LAST_POS);
                    if (flush_reg && (pos_reg != LAST_POS))
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        if (flush_reg)
                        begin
                            seen_next  = '0;
                            flush_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg  <= '0;
            pend_reg  <= '0;
            pos_reg   <= '0;
            flush_reg <= 1'b0;
            idx_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            flush_reg <= flush_next;
            idx_reg   <= idx_next;
            dcnt_reg  <= dcnt_next;
        end
    end

endmodule

// File: rtl/mwof_checker.sv
// Port-level checker for median_window_outlier_filter_core, bound to the top.
// Depends on median_window_outlier_filter_core_defines.svh.
`include "median_window_outlier_filter_core_defines.svh"

module mwof_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    input logic                              m_tlast
);

    // A stalled output beat holds
    `MWOF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat changed while stalled")

    // Pad bits above out_y stay zero
    `MWOF_ASSERT_SAME(a_out_pad, clk, rst_n, m_tvalid, (m_tdata >> (2 * COORD_BITS)) == '0, "nonzero pad bits in output beat")

    // A run end always starts a flush, so input is held off next cycle
    `MWOF_ASSERT_NEXT(a_flush_busy, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready, "input ready right after run end")

    // The input side only goes busy after taking a beat
    `MWOF_ASSERT_SAME(a_busy_cause, clk, rst_n, $fell(s_tready), $past(s_tvalid && s_tready), "input ready dropped without a beat")

endmodule

bind median_window_outlier_filter_core mwof_checker #(
    .COORD_BITS (COORD_BITS)
) u_mwof_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for median_window_outlier_filter_core: directed table, then random runs.
// Uses a built-in window filter predictor. Depends on rtl/mwof_pkg.sv and the core RTL.
module testbench;

    localparam int CB    = 10;
    localparam int WIN   = 7;
    localparam int HALF  = WIN / 2;
    localparam int DW    = ((2 * CB + 7) / 8) * 8;
    localparam int CMAX  = (1 << CB) - 1;
    localparam int QUIET = 64;
    localparam int LIMIT = 2000;
    localparam int DIR_ROWS = 23;
    localparam logic [mwof_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic [CB-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } fpoint_t;

    typedef enum logic {ROW_POINT, ROW_LIMITS} row_kind_t;

    // point row: a = x, b = y, c = typed out_y when fixed is set
    // limits row: a = up_limit, b = down_limit, c = down_offset
    typedef struct packed {
        row_kind_t kind;
        coord_t    a;
        coord_t    b;
        coord_t    c;
        logic      last;
        logic      fixed;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DW-1:0]     s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DW-1:0]     m_tdata;
    logic              m_tlast;
    logic              cfg_we = 1'b0;
    logic [mwof_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CB-1:0]     cfg_data = '0;

    // typed expectation attached to the pending beat
    logic              fixed_row = 1'b0;
    coord_t            fixed_y = '0;

    int                src_idle_pct = 0;
    int                sink_stall_pct = 0;
    int                errors = 0;

    // predictor state
    coord_t            win_x [WIN] = '{default: '0};
    coord_t            win_y [WIN] = '{default: '0};
    int                seen = 0;
    int                unsent = 0;
    int                up_lim = mwof_pkg::UP_LIMIT_RST;
    int                down_lim = mwof_pkg::DOWN_LIMIT_RST;
    int                down_off = mwof_pkg::DOWN_OFFSET_RST;
    fpoint_t           filtered_q [$];

    stim_row_t dir_rows [DIR_ROWS] = '{
        // one-point runs at both extremes pass straight through
        '{ROW_POINT, 10'd0,    10'd0,    10'd0,    1'b1, 1'b1},
        '{ROW_POINT, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1},
        // short run: mean reference only
        '{ROW_POINT, 10'd10,   10'd100,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd11,   10'd300,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd12,   10'd100,  10'd0,    1'b1, 1'b0},
        // nine points with a spike each way, median in the middle
        '{ROW_POINT, 10'd20,   10'd500,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd21,   10'd500,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd22,   10'd500,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd23,   10'd800,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd24,   10'd500,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd25,   10'd500,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd26,   10'd200,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd27,   10'd500,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd28,   10'd500,  10'd0,    1'b1, 1'b0},
        // zero thresholds and full offset: saturation of out_y
        '{ROW_LIMITS, 10'd0,   10'd0,    10'd1023, 1'b0, 1'b0},
        '{ROW_POINT, 10'd1023, 10'd1000, 10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd0,    10'd0,    10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd512,  10'd1023, 10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd513,  10'd512,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd514,  10'd3,    10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd515,  10'd1020, 10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd516,  10'd700,  10'd0,    1'b0, 1'b0},
        '{ROW_POINT, 10'd517,  10'd1023, 10'd0,    1'b1, 1'b0}
    };

    median_window_outlier_filter_core #(
        .WINDOW_SIZE (WIN),
        .COORD_BITS  (CB)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Reference y for window slot pos, n valid slots ending at the newest one
    function automatic coord_t window_reference(int pos, int n);
        coord_t ys [WIN];
        coord_t t;
        int     lo;
        int     hi;
        int     cnt;
        int     sum;
        lo = pos - HALF;
        hi = pos + HALF;
        if (lo < WIN - n)
            lo = WIN - n;
        if (hi > WIN - 1)
            hi = WIN - 1;
        cnt = 0;
        sum = 0;
        for (int i = lo; i <= hi; i++)
        begin
            ys[cnt] = win_y[i];
            sum += win_y[i];
            cnt++;
        end
        // clipped window: floor of the mean
        if (cnt < WIN)
            return coord_t'(sum / cnt);
        // full window: median
        for (int i = 0; i < WIN - 1; i++)
            for (int j = 0; j < WIN - 1 - i; j++)
                if (ys[j] > ys[j + 1])
                begin
                    t = ys[j];
                    ys[j] = ys[j + 1];
                    ys[j + 1] = t;
                end
        return ys[WIN / 2];
    endfunction

    // Outlier decision for one slot
    function automatic fpoint_t filter_slot(int pos, int n, logic last);
        int r;
        int yv;
        int res;
        r = window_reference(pos, n);
        yv = win_y[pos];
        if (r - yv > up_lim)
            res = r;
        else if (yv - r > down_lim)
        begin
            res = r + down_off;
            if (res > CMAX)
                res = CMAX;
        end
        else
            res = yv;
        return '{x: win_x[pos], y: coord_t'(res), last: last};
    endfunction

    // Push one accepted point through the window, queue the points it releases
    task automatic run_filter(input coord_t px, input coord_t py, input logic last,
                              output int produced);
        int n;
        produced = 0;
        for (int i = 0; i < WIN - 1; i++)
        begin
            win_x[i] = win_x[i + 1];
            win_y[i] = win_y[i + 1];
        end
        win_x[WIN - 1] = px;
        win_y[WIN - 1] = py;
        if (seen < WIN)
            seen++;
        if (unsent < HALF + 1)
            unsent++;
        n = seen;
        if (last)
        begin
            // run end flushes everything still held
            for (int i = WIN - unsent; i < WIN; i++)
            begin
                filtered_q.insert(filtered_q.size(), filter_slot(i, n, i == WIN - 1));
                produced++;
            end
            seen = 0;
            unsent = 0;
        end
        else if (unsent > HALF)
        begin
            filtered_q.insert(filtered_q.size(), filter_slot(WIN - 1 - HALF, n, 1'b0));
            produced = 1;
            unsent = HALF;
        end
    endtask

    task automatic set_register(input logic [mwof_pkg::CFG_IDX_W-1:0] idx, input coord_t val);
        case (idx)
            mwof_pkg::REG_UP_LIMIT:    up_lim = val;
            mwof_pkg::REG_DOWN_LIMIT:  down_lim = val;
            mwof_pkg::REG_DOWN_OFFSET: down_off = val;
            default:                   ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    // Entered and left just after a falling edge; cfg_we stays high for the caller
    task automatic write_reg(input logic [mwof_pkg::CFG_IDX_W-1:0] idx, input coord_t val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        set_register(idx, val);
        @(negedge clk);
    endtask

    // Drain: lower valid, wait for every pending point, then let the core go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (filtered_q.size() != 0)
            @(negedge clk);
        repeat (QUIET) @(negedge clk);
    endtask

    task automatic apply_limits(input coord_t up, input coord_t down, input coord_t off);
        settle();
        write_reg(mwof_pkg::REG_UP_LIMIT, up);
        write_reg(mwof_pkg::REG_DOWN_LIMIT, down);
        write_reg(mwof_pkg::REG_DOWN_OFFSET, off);
        write_reg(REG_UNUSED, coord_t'($urandom));
        cfg_we <= 1'b0;
    endtask

    // One beat on the input side, with random idle cycles ahead of it
    task automatic push_point(input coord_t px, input coord_t py, input logic last,
                              input logic fixed, input coord_t fy);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {{(DW - 2 * CB){1'b0}}, py, px};
        s_tlast   <= last;
        fixed_row <= fixed;
        fixed_y   <= fy;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // A contour run: mostly a smooth track with spikes, sometimes pure noise
    task automatic send_run(input int len);
        coord_t px;
        int     base;
        int     yv;
        int     spike;
        logic   smooth;
        px = coord_t'($urandom);
        base = $urandom_range(0, CMAX);
        smooth = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++)
        begin
            if (!smooth)
                yv = $urandom_range(0, CMAX);
            else
            begin
                yv = base + int'($urandom_range(0, 16)) - 8;
                if ($urandom_range(0, 4) == 0)
                begin
                    spike = $urandom_range(20, 400);
                    if ($urandom_range(0, 1) == 1)
                        yv += spike;
                    else
                        yv -= spike;
                end
            end
            if (yv < 0)
                yv = 0;
            if (yv > CMAX)
                yv = CMAX;
            push_point(px, coord_t'(yv), i == len - 1, 1'b0, '0);
            px = px + coord_t'($urandom_range(0, 3));
        end
    endtask

    // Output ready with random stalls
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // Beat monitor: predict on input beats, compare on output beats
    always @(posedge clk)
    begin : beat_monitor
        fpoint_t got;
        fpoint_t want;
        int      produced;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                run_filter(s_tdata[CB-1:0], s_tdata[2*CB-1:CB], s_tlast, produced);
                if (fixed_row)
                begin
                    repeat (produced) void'(filtered_q.pop_back());
                    filtered_q.insert(filtered_q.size(),
                                      '{x: s_tdata[CB-1:0], y: fixed_y, last: 1'b1});
                end
            end
            if (m_tvalid && m_tready)
            begin
                got = '{x: m_tdata[CB-1:0], y: m_tdata[2*CB-1:CB], last: m_tlast};
                if (filtered_q.size() == 0)
                    report_mismatch($sformatf("unexpected beat x=%0d y=%0d last=%0b",
                                              got.x, got.y, got.last));
                else
                begin
                    want = filtered_q.pop_front();
                    if (got.x != want.x)
                        report_mismatch($sformatf("out_x got %0d want %0d", got.x, want.x));
                    if (got.y != want.y)
                        report_mismatch($sformatf("out_y got %0d want %0d (x=%0d)",
                                                  got.y, want.y, want.x));
                    if (got.last != want.last)
                        report_mismatch($sformatf("out_last got %0b want %0b (x=%0d)",
                                                  got.last, want.last, want.x));
                end
            end
        end
    end

    // Watchdog: too many cycles without any beat or register write
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("median_window_outlier_filter_core regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int total;
        int len;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, light idling on both sides
        src_idle_pct = 7;
        sink_stall_pct = 7;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_LIMITS)
                apply_limits(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c);
            else
                push_point(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last,
                           dir_rows[i].fixed, dir_rows[i].c);
        end

        // random phases: each drains, rewrites the limits, then sends whole runs
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
                default: begin src_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            case (p)
                0: apply_limits(coord_t'(mwof_pkg::UP_LIMIT_RST),
                                coord_t'(mwof_pkg::DOWN_LIMIT_RST),
                                coord_t'(mwof_pkg::DOWN_OFFSET_RST));
                1: apply_limits('0, '0, '0);
                2: apply_limits(coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMAX));
                3: apply_limits(coord_t'(CMAX), '0, coord_t'(CMAX));
                4, 5: apply_limits(coord_t'($urandom_range(0, 60)),
                                   coord_t'($urandom_range(0, 60)),
                                   coord_t'($urandom_range(0, 60)));
                default: apply_limits(coord_t'($urandom), coord_t'($urandom),
                                      coord_t'($urandom));
            endcase
            total = 0;
            while (total < 6)
            begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(1, 3);
                else
                    len = $urandom_range(4, 12);
                send_run(len);
                total += len;
            end
        end

        settle();
        if (filtered_q.size() != 0)
            report_mismatch($sformatf("%0d filtered points never came out", filtered_q.size()));
        if (errors == 0)
            $display("median_window_outlier_filter_core regression: pass");
        else
            $display("median_window_outlier_filter_core regression: fail");
        $finish;
    end

endmodule

// File: median_window_outlier_filter_core.f
+incdir+rtl
rtl/mwof_pkg.sv
rtl/mwof_datapath.sv
rtl/mwof_ctrl.sv
rtl/median_window_outlier_filter_core.sv
rtl/mwof_checker.sv
test/testbench.sv
